/* src/mi4_pkg.sv */
// Shared types, constants and the cofactor term table for the 4x4 matrix inverse.
package mi4_pkg;

   localparam int DATA_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int IW             = 64;
   localparam int THR_W          = 16;
   localparam logic [THR_W-1:0] THR_RESET = 16'd1;
   localparam int RSP_USER_W     = 8;

   typedef logic signed [IW-1:0] ival_type;

   localparam ival_type IVAL_MAX = {1'b0, {(IW-1){1'b1}}};
   localparam ival_type IVAL_MIN = {1'b1, {(IW-1){1'b0}}};

   // Operand register sources.
   localparam logic [1:0] OPA_HOLD = 2'd0;
   localparam logic [1:0] OPA_MAT  = 2'd1;
   localparam logic [1:0] OPA_MUL  = 2'd2;
   localparam logic [1:0] OPA_COF  = 2'd3;

   localparam logic [2:0] OPB_HOLD  = 3'd0;
   localparam logic [2:0] OPB_MAT   = 3'd1;
   localparam logic [2:0] OPB_ELEMC = 3'd2;
   localparam logic [2:0] OPB_COF   = 3'd3;
   localparam logic [2:0] OPB_FAC   = 3'd4;

   typedef struct packed {
      logic       mat_we;
      logic [3:0] mat_addr;
      logic       cof_we;
      logic [3:0] cof_addr;
      logic [1:0] opa_sel;
      logic [2:0] opb_sel;
      logic       elemc_ld;
      logic       mul_start;
      logic       acc_ld;
      logic       acc_clr;
      logic       acc_sub;
      logic       det_ld;
      logic       det_clr;
      logic       fac_chk;
      logic       fac_div;
      logic       out_ld;
      logic [3:0] out_index;
      logic       out_last;
   } cmd_type;

   typedef struct packed {
      logic mul_done;
      logic div_done;
      logic sing_now;
   } status_type;

   // Element indices of the six triple products of each cofactor, first term
   // in the top nibbles.
   localparam logic [71:0] COF_TAB [16] = '{
      72'h5AF5EB69F6DB79E7DA,
      72'h1AF1EB29F2DB39E3DA,
      72'h16F1E725F2D735E3D6,
      72'h16B1A725B29735A396,
      72'h4AF4EB68F6CB78E7CA,
      72'h0AF0EB28F2CB38E3CA,
      72'h06F0E724F2C734E3C6,
      72'h06B0A724B28734A386,
      72'h49F4DB58F5CB78D7C9,
      72'h09F0DB18F1CB38D3C9,
      72'h05F0D714F1C734D3C5,
      72'h05B09714B187349385,
      72'h49E4DA58E5CA68D6C9,
      72'h09E0DA18E1CA28D2C9,
      72'h05E0D614E1C624D2C5,
      72'h05A09614A186249285
   };

   // Bit t: term t has a leading sign; bit i: cofactor i leads positive.
   localparam logic [5:0]  TERM_POS = 6'b011001;
   localparam logic [15:0] LEAD_POS = 16'hA5A5;

   function automatic logic [3:0] cof_elem(input logic [3:0] idx, input logic [2:0] term,
                                           input logic [1:0] k);
      logic [71:0] row;
      int          pos;
      row = COF_TAB[idx];
      pos = 17 - (int'(term) * 3 + int'(k));
      return row[pos*4 +: 4];
   endfunction

   function automatic ival_type sat_add(input ival_type a, input ival_type b,
                                        input logic sub);
      logic signed [IW:0] s;
      s = sub ? ({a[IW-1], a} - {b[IW-1], b}) : ({a[IW-1], a} + {b[IW-1], b});
      if (s[IW] != s[IW-1]) begin
         return s[IW] ? IVAL_MIN : IVAL_MAX;
      end
      return s[IW-1:0];
   endfunction

endpackage

/* src/mi4_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module mi4_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* src/mi4_mul.sv */
// Multicycle signed fixed-point multiplier built from 32x32 partial products.
module mi4_mul #(
   parameter int FRAC_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  mi4_pkg::ival_type     a,
   input  mi4_pkg::ival_type     b,
   output logic                  done,
   output mi4_pkg::ival_type     result
);
   import mi4_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [2:0]        step_ff, step_in;
   logic [IW-1:0]     mag_a_ff, mag_a_in, mag_b_ff, mag_b_in;
   logic              neg_ff, neg_in;
   logic [2*IW-1:0]   acc_ff, acc_in;
   ival_type          res_ff, res_in;

   logic [31:0]       half_a, half_b;
   logic [63:0]       pp;
   logic [2*IW-1:0]   pp_sh;
   logic [2*IW-1:0]   shifted;
   logic              fits;

   always_comb begin
      half_a  = step_ff[1] ? mag_a_ff[63:32] : mag_a_ff[31:0];
      half_b  = step_ff[0] ? mag_b_ff[63:32] : mag_b_ff[31:0];
      pp      = half_a * half_b;
      unique case ({step_ff[1], step_ff[0]})
         2'b00:   pp_sh = {64'd0, pp};
         2'b11:   pp_sh = {pp, 64'd0};
         default: pp_sh = {32'd0, pp, 32'd0};
      endcase
      shifted = 128'($signed(acc_ff) >>> FRAC_BITS);
      fits    = (&shifted[2*IW-1:IW-1]) | ~(|shifted[2*IW-1:IW-1]);

      busy_in  = busy_ff;
      done_in  = 1'b0;
      step_in  = step_ff;
      mag_a_in = mag_a_ff;
      mag_b_in = mag_b_ff;
      neg_in   = neg_ff;
      acc_in   = acc_ff;
      res_in   = res_ff;
      if (start) begin
         busy_in  = 1'b1;
         step_in  = 3'd0;
         mag_a_in = a[IW-1] ? (64'd0 - a) : a;
         mag_b_in = b[IW-1] ? (64'd0 - b) : b;
         neg_in   = a[IW-1] ^ b[IW-1];
         acc_in   = '0;
      end else if (busy_ff) begin
         step_in = step_ff + 3'd1;
         if (step_ff < 3'd4) begin
            acc_in = acc_ff + pp_sh;
         end else if (step_ff == 3'd4) begin
            acc_in = neg_ff ? (128'd0 - acc_ff) : acc_ff;
         end else begin
            res_in  = fits ? shifted[IW-1:0] : (acc_ff[2*IW-1] ? IVAL_MIN : IVAL_MAX);
            done_in = 1'b1;
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= 3'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      mag_a_ff <= mag_a_in;
      mag_b_ff <= mag_b_in;
      neg_ff   <= neg_in;
      acc_ff   <= acc_in;
      res_ff   <= res_in;
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

/* src/mi4_div.sv */
// Restoring divider that forms 2^(2*FRAC_BITS) / divisor, one quotient bit a cycle.
module mi4_div #(
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [63:0]          divisor,
   output logic                 done,
   output logic [63:0]          quot
);
   localparam int NUM_W = 2 * FRAC_BITS + 1;
   localparam int CNT_W = $clog2(NUM_W + 1);
   localparam logic [CNT_W-1:0] CNT_START = CNT_W'(NUM_W);

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             done_ff, done_in;
   logic [64:0]      rem_ff, rem_in;
   logic [63:0]      div_ff, div_in;
   logic [NUM_W-1:0] q_ff, q_in;
   logic [64:0]      trial;
   logic             take;

   always_comb begin
      // The dividend is a single one bit, so only the first step shifts it in.
      trial   = {rem_ff[63:0], (cnt_ff == CNT_START)};
      take    = trial >= {1'b0, div_ff};
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      rem_in  = rem_ff;
      div_in  = div_ff;
      q_in    = q_ff;
      if (start) begin
         cnt_in = CNT_START;
         rem_in = '0;
         div_in = divisor;
         q_in   = '0;
      end else if (cnt_ff != '0) begin
         rem_in = take ? (trial - {1'b0, div_ff}) : trial;
         q_in   = {q_ff[NUM_W-2:0], take};
         cnt_in = cnt_ff - 1'b1;
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      div_ff <= div_in;
      q_ff   <= q_in;
   end

   assign done = done_ff;
   assign quot = 64'(q_ff);

endmodule

/* src/mi4_dpath.sv */
// Datapath: element and cofactor stores, operand registers, multiplier, divider.
module mi4_dpath #(
   parameter int DATA_WIDTH = mi4_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = mi4_pkg::FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  mi4_pkg::cmd_type              cmd,
   output mi4_pkg::status_type           status,
   input  logic                          csr_we,
   input  logic [mi4_pkg::THR_W-1:0]     csr_wdata,
   input  logic [DATA_WIDTH-1:0]         elem_value,
   output logic [DATA_WIDTH-1:0]         out_value,
   output logic [3:0]                    out_index,
   output logic                          out_singular,
   output logic                          out_last
);
   import mi4_pkg::*;

   logic [THR_W-1:0]      thr_ff;
   ival_type              opa_ff, opa_in, opb_ff, opb_in, elemc_ff;
   ival_type              acc_ff, det_ff, fac_ff;
   logic                  sing_ff;
   logic [DATA_WIDTH-1:0] out_value_ff;
   logic [3:0]            out_index_ff;
   logic                  out_last_ff;

   logic [DATA_WIDTH-1:0] mat_rdata;
   logic [IW-1:0]         cof_rdata;
   ival_type              mat_val, cof_val, acc_next, det_next, mul_res, fac_q;
   logic                  mul_done, div_done;
   logic [63:0]           det_mag, quot;
   logic                  sing_now, out_fits;

   mi4_ram #(.WIDTH(DATA_WIDTH), .DEPTH(16)) u_mat_ram (
      .clock (clock),
      .we    (cmd.mat_we),
      .waddr (cmd.mat_addr),
      .wdata (elem_value),
      .raddr (cmd.mat_addr),
      .rdata (mat_rdata)
   );

   mi4_ram #(.WIDTH(IW), .DEPTH(16)) u_cof_ram (
      .clock (clock),
      .we    (cmd.cof_we),
      .waddr (cmd.cof_addr),
      .wdata (acc_next),
      .raddr (cmd.cof_addr),
      .rdata (cof_rdata)
   );

   mi4_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.mul_start),
      .a      (opa_ff),
      .b      (opb_ff),
      .done   (mul_done),
      .result (mul_res)
   );

   mi4_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.fac_chk & ~sing_now),
      .divisor (det_mag),
      .done    (div_done),
      .quot    (quot)
   );

   always_comb begin
      mat_val  = {{(IW-DATA_WIDTH){mat_rdata[DATA_WIDTH-1]}}, mat_rdata};
      cof_val  = cof_rdata;
      acc_next = sat_add(cmd.acc_clr ? ival_type'(0) : acc_ff, mul_res, cmd.acc_sub);
      det_next = sat_add(cmd.det_clr ? ival_type'(0) : det_ff, mul_res, 1'b0);
      det_mag  = det_ff[IW-1] ? (64'd0 - det_ff) : det_ff;
      sing_now = !(det_mag > 64'(thr_ff));
      fac_q    = det_ff[IW-1] ? (64'd0 - quot) : quot;
      out_fits = (&mul_res[IW-1:DATA_WIDTH-1]) | ~(|mul_res[IW-1:DATA_WIDTH-1]);

      unique case (cmd.opa_sel)
         OPA_MAT: opa_in = mat_val;
         OPA_MUL: opa_in = mul_res;
         OPA_COF: opa_in = cof_val;
         default: opa_in = opa_ff;
      endcase
      unique case (cmd.opb_sel)
         OPB_MAT:   opb_in = mat_val;
         OPB_ELEMC: opb_in = elemc_ff;
         OPB_COF:   opb_in = cof_val;
         OPB_FAC:   opb_in = fac_ff;
         default:   opb_in = opb_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else if (csr_we) begin
         thr_ff <= csr_wdata;
      end
      opa_ff <= opa_in;
      opb_ff <= opb_in;
      if (cmd.elemc_ld) begin
         elemc_ff <= mat_val;
      end
      if (cmd.acc_ld) begin
         acc_ff <= acc_next;
      end
      if (cmd.det_ld) begin
         det_ff <= det_next;
      end
      if (cmd.fac_chk) begin
         sing_ff <= sing_now;
         if (sing_now) begin
            fac_ff <= det_ff;
         end
      end else if (cmd.fac_div) begin
         fac_ff <= fac_q;
      end
      if (cmd.out_ld) begin
         out_value_ff <= out_fits ? mul_res[DATA_WIDTH-1:0]
                       : (mul_res[IW-1] ? {1'b1, {(DATA_WIDTH-1){1'b0}}}
                                        : {1'b0, {(DATA_WIDTH-1){1'b1}}});
         out_index_ff <= cmd.out_index;
         out_last_ff  <= cmd.out_last;
      end
   end

   assign status.mul_done = mul_done;
   assign status.div_done = div_done;
   assign status.sing_now = sing_now;

   assign out_value    = out_value_ff;
   assign out_index    = out_index_ff;
   assign out_singular = sing_ff;
   assign out_last     = out_last_ff;

endmodule

/* src/mi4_ctrl.sv */
// Controller: sequences loading, cofactor terms, determinant, factor and results.
module mi4_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_tlast,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  mi4_pkg::status_type  status,
   output mi4_pkg::cmd_type     cmd
);
   import mi4_pkg::*;

   localparam logic [4:0] ST_LOAD  = 5'd0;
   localparam logic [4:0] ST_C_A0  = 5'd1;
   localparam logic [4:0] ST_C_A1  = 5'd2;
   localparam logic [4:0] ST_C_A2  = 5'd3;
   localparam logic [4:0] ST_C_M1  = 5'd4;
   localparam logic [4:0] ST_C_W1  = 5'd5;
   localparam logic [4:0] ST_C_M2  = 5'd6;
   localparam logic [4:0] ST_C_W2  = 5'd7;
   localparam logic [4:0] ST_D_A0  = 5'd8;
   localparam logic [4:0] ST_D_A1  = 5'd9;
   localparam logic [4:0] ST_D_M   = 5'd10;
   localparam logic [4:0] ST_D_W   = 5'd11;
   localparam logic [4:0] ST_F_CHK = 5'd12;
   localparam logic [4:0] ST_F_DIV = 5'd13;
   localparam logic [4:0] ST_O_A   = 5'd14;
   localparam logic [4:0] ST_O_B   = 5'd15;
   localparam logic [4:0] ST_O_M   = 5'd16;
   localparam logic [4:0] ST_O_W   = 5'd17;
   localparam logic [4:0] ST_O_H   = 5'd18;

   logic [4:0] state_ff, state_in;
   logic [3:0] load_cnt_ff, load_cnt_in;
   logic [3:0] idx_ff, idx_in;
   logic [2:0] term_ff, term_in;

   always_comb begin
      cmd         = '0;
      state_in    = state_ff;
      load_cnt_in = load_cnt_ff;
      idx_in      = idx_ff;
      term_in     = term_ff;
      req_tready  = 1'b0;
      rsp_tvalid  = 1'b0;

      unique case (state_ff)
         ST_LOAD: begin
            req_tready   = 1'b1;
            cmd.mat_addr = load_cnt_ff;
            if (req_tvalid) begin
               cmd.mat_we = 1'b1;
               if (req_tlast) begin
                  load_cnt_in = 4'd0;
                  idx_in      = 4'd0;
                  term_in     = 3'd0;
                  state_in    = ST_C_A0;
               end else begin
                  load_cnt_in = load_cnt_ff + 4'd1;
               end
            end
         end
         ST_C_A0: begin
            cmd.mat_addr = cof_elem(idx_ff, term_ff, 2'd0);
            state_in     = ST_C_A1;
         end
         ST_C_A1: begin
            cmd.mat_addr = cof_elem(idx_ff, term_ff, 2'd1);
            cmd.opa_sel  = OPA_MAT;
            state_in     = ST_C_A2;
         end
         ST_C_A2: begin
            cmd.mat_addr = cof_elem(idx_ff, term_ff, 2'd2);
            cmd.opb_sel  = OPB_MAT;
            state_in     = ST_C_M1;
         end
         ST_C_M1: begin
            cmd.elemc_ld  = 1'b1;
            cmd.mul_start = 1'b1;
            state_in      = ST_C_W1;
         end
         ST_C_W1: begin
            if (status.mul_done) begin
               cmd.opa_sel = OPA_MUL;
               cmd.opb_sel = OPB_ELEMC;
               state_in    = ST_C_M2;
            end
         end
         ST_C_M2: begin
            cmd.mul_start = 1'b1;
            state_in      = ST_C_W2;
         end
         ST_C_W2: begin
            cmd.cof_addr = idx_ff;
            if (status.mul_done) begin
               cmd.acc_ld  = 1'b1;
               cmd.acc_clr = (term_ff == 3'd0);
               cmd.acc_sub = TERM_POS[term_ff] != LEAD_POS[idx_ff];
               cmd.cof_we  = (term_ff == 3'd5);
               state_in    = ST_C_A0;
               if (term_ff == 3'd5) begin
                  term_in = 3'd0;
                  idx_in  = idx_ff + 4'd1;
                  if (idx_ff == 4'd15) begin
                     state_in = ST_D_A0;
                  end
               end else begin
                  term_in = term_ff + 3'd1;
               end
            end
         end
         ST_D_A0: begin
            cmd.mat_addr = {idx_ff[1:0], 2'b00};
            cmd.cof_addr = idx_ff;
            state_in     = ST_D_A1;
         end
         ST_D_A1: begin
            cmd.opa_sel = OPA_MAT;
            cmd.opb_sel = OPB_COF;
            state_in    = ST_D_M;
         end
         ST_D_M: begin
            cmd.mul_start = 1'b1;
            state_in      = ST_D_W;
         end
         ST_D_W: begin
            if (status.mul_done) begin
               cmd.det_ld  = 1'b1;
               cmd.det_clr = (idx_ff == 4'd0);
               if (idx_ff == 4'd3) begin
                  idx_in   = 4'd0;
                  state_in = ST_F_CHK;
               end else begin
                  idx_in   = idx_ff + 4'd1;
                  state_in = ST_D_A0;
               end
            end
         end
         ST_F_CHK: begin
            cmd.fac_chk = 1'b1;
            state_in    = status.sing_now ? ST_O_A : ST_F_DIV;
         end
         ST_F_DIV: begin
            if (status.div_done) begin
               cmd.fac_div = 1'b1;
               state_in    = ST_O_A;
            end
         end
         ST_O_A: begin
            cmd.cof_addr = idx_ff;
            state_in     = ST_O_B;
         end
         ST_O_B: begin
            cmd.opa_sel = OPA_COF;
            cmd.opb_sel = OPB_FAC;
            state_in    = ST_O_M;
         end
         ST_O_M: begin
            cmd.mul_start = 1'b1;
            state_in      = ST_O_W;
         end
         ST_O_W: begin
            cmd.out_index = idx_ff;
            cmd.out_last  = (idx_ff == 4'd15);
            if (status.mul_done) begin
               cmd.out_ld = 1'b1;
               state_in   = ST_O_H;
            end
         end
         ST_O_H: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               idx_in   = idx_ff + 4'd1;
               state_in = (idx_ff == 4'd15) ? ST_LOAD : ST_O_A;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_LOAD;
         load_cnt_ff <= 4'd0;
         idx_ff      <= 4'd0;
         term_ff     <= 3'd0;
      end else begin
         state_ff    <= state_in;
         load_cnt_ff <= load_cnt_in;
         idx_ff      <= idx_in;
         term_ff     <= term_in;
      end
   end

endmodule

/* src/matrix_inverse_4x4.sv */
// Top level of the 4x4 fixed-point matrix inverse by cofactors.
//
//   channel  direction  tdata                  tuser                      tlast
//   req      in         elem_value             -                          elem_last
//   rsp      out        result_value           result_index, singular     result_last
//   csr      in         det_threshold (write)  -                          -
//
// Elements are taken back to back while the block is loading. After the last element
// the block runs the 192 cofactor multiplies and the determinant on one shared
// multiplier and the reciprocal on the divider, then hands out the results one by one.
// No element is taken while a matrix is being worked on or its results delivered.
// Reset is synchronous and sets the threshold to one.
module matrix_inverse_4x4 #(
   parameter int DATA_WIDTH = mi4_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = mi4_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [mi4_pkg::THR_W-1:0]           csr_wdata,   // det_threshold
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [((DATA_WIDTH+7)/8)*8-1:0]     req_tdata,   // elem_value
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [((DATA_WIDTH+7)/8)*8-1:0]     rsp_tdata,   // result_value
   output logic [mi4_pkg::RSP_USER_W-1:0]      rsp_tuser,   // result_index, singular
   output logic                                rsp_tlast
);
   import mi4_pkg::*;

   cmd_type               cmd;
   status_type            status;
   logic [DATA_WIDTH-1:0] out_value;
   logic [3:0]            out_index;
   logic                  out_singular;

   mi4_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   mi4_dpath #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .csr_we       (csr_we),
      .csr_wdata    (csr_wdata),
      .elem_value   (req_tdata[DATA_WIDTH-1:0]),
      .out_value    (out_value),
      .out_index    (out_index),
      .out_singular (out_singular),
      .out_last     (rsp_tlast)
   );

   always_comb begin
      rsp_tdata                 = '0;
      rsp_tdata[DATA_WIDTH-1:0] = out_value;
      rsp_tuser                 = '0;
      rsp_tuser[3:0]            = out_index;
      rsp_tuser[4]              = out_singular;
   end

endmodule

/* tb/sv/tb_matrix_inverse_4x4.sv */
// Self-checking testbench for the 4x4 fixed-point matrix inverse.
`timescale 1ns / 1ps

module tb_matrix_inverse_4x4;
   import mi4_pkg::*;

   localparam int FB = 16;

   // Element indices of the six triple products of each cofactor.
   localparam int TERM_ELEM [16][6][3] = '{
      '{'{5,10,15},'{5,14,11},'{6,9,15},'{6,13,11},'{7,9,14},'{7,13,10}},
      '{'{1,10,15},'{1,14,11},'{2,9,15},'{2,13,11},'{3,9,14},'{3,13,10}},
      '{'{1,6,15},'{1,14,7},'{2,5,15},'{2,13,7},'{3,5,14},'{3,13,6}},
      '{'{1,6,11},'{1,10,7},'{2,5,11},'{2,9,7},'{3,5,10},'{3,9,6}},
      '{'{4,10,15},'{4,14,11},'{6,8,15},'{6,12,11},'{7,8,14},'{7,12,10}},
      '{'{0,10,15},'{0,14,11},'{2,8,15},'{2,12,11},'{3,8,14},'{3,12,10}},
      '{'{0,6,15},'{0,14,7},'{2,4,15},'{2,12,7},'{3,4,14},'{3,12,6}},
      '{'{0,6,11},'{0,10,7},'{2,4,11},'{2,8,7},'{3,4,10},'{3,8,6}},
      '{'{4,9,15},'{4,13,11},'{5,8,15},'{5,12,11},'{7,8,13},'{7,12,9}},
      '{'{0,9,15},'{0,13,11},'{1,8,15},'{1,12,11},'{3,8,13},'{3,12,9}},
      '{'{0,5,15},'{0,13,7},'{1,4,15},'{1,12,7},'{3,4,13},'{3,12,5}},
      '{'{0,5,11},'{0,9,7},'{1,4,11},'{1,8,7},'{3,4,9},'{3,8,5}},
      '{'{4,9,14},'{4,13,10},'{5,8,14},'{5,12,10},'{6,8,13},'{6,12,9}},
      '{'{0,9,14},'{0,13,10},'{1,8,14},'{1,12,10},'{2,8,13},'{2,12,9}},
      '{'{0,5,14},'{0,13,6},'{1,4,14},'{1,12,6},'{2,4,13},'{2,12,5}},
      '{'{0,5,10},'{0,9,6},'{1,4,10},'{1,8,6},'{2,4,9},'{2,8,5}}
   };
   localparam logic [15:0] LEADS_POS = 16'b1010010110100101; // bit i: cofactor i
   localparam logic [5:0]  TERMS_POS = 6'b011001;             // bit t: term t

   typedef struct packed {
      logic signed [31:0] value;
      logic [3:0]         index;
      logic               singular;
      logic               last;
   } inv_elem_type;

   typedef struct {
      logic signed [31:0] value;
      logic               last;
      logic               has_exp;
      logic signed [31:0] exp_value;
      logic               exp_singular;
   } elem_row_type;

   logic clock, reset;
   logic csr_we;
   logic [15:0] csr_wdata;
   logic req_tvalid, req_tready, req_tlast;
   logic [31:0] req_tdata;
   logic rsp_tvalid, rsp_tready, rsp_tlast;
   logic [31:0] rsp_tdata;
   logic [7:0] rsp_tuser;

   matrix_inverse_4x4 u_top (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tlast(req_tlast), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #500ms;
      $display("** matrix_inverse_4x4: FAILED **");
      $finish;
   end

   // Predictor state.
   ival_type     mat_copy [16];
   logic [3:0]   fill_ptr;
   logic [15:0]  thresh_copy;
   inv_elem_type inverse_q [$];
   int           errors;
   int           matrices;
   int           results_seen;
   bit           stall_off;

   function automatic ival_type fx_mul(ival_type x, ival_type y);
      logic signed [127:0] p;
      logic signed [127:0] s;
      p = 128'(signed'(x)) * 128'(signed'(y));
      s = p >>> FB;
      if (s > 128'(signed'(IVAL_MAX))) return IVAL_MAX;
      if (s < 128'(signed'(IVAL_MIN))) return IVAL_MIN;
      return s[63:0];
   endfunction

   function automatic ival_type fx_addsub(ival_type a, ival_type b, logic sub);
      logic signed [64:0] s;
      s = sub ? (65'(a) - 65'(b)) : (65'(a) + 65'(b));
      if (s > 65'(signed'(IVAL_MAX))) return IVAL_MAX;
      if (s < 65'(signed'(IVAL_MIN))) return IVAL_MIN;
      return s[63:0];
   endfunction

   // Loads one element and, on the last one, queues the 16 inverse elements.
   task automatic predict_inverse(logic signed [31:0] v, logic lst);
      ival_type     cof [16];
      ival_type     acc, det, fac, t;
      logic [63:0]  mag, q;
      logic         sing;
      logic         pos;
      inv_elem_type e;
      mat_copy[fill_ptr] = 64'(v);
      if (!lst) begin
         fill_ptr = fill_ptr + 4'd1;
         return;
      end
      fill_ptr = 4'd0;
      for (int i = 0; i < 16; i++) begin
         acc = '0;
         for (int k = 0; k < 6; k++) begin
            t = fx_mul(fx_mul(mat_copy[TERM_ELEM[i][k][0]], mat_copy[TERM_ELEM[i][k][1]]),
                       mat_copy[TERM_ELEM[i][k][2]]);
            pos = (TERMS_POS[k] == LEADS_POS[i]);
            acc = fx_addsub(acc, t, !pos);
         end
         cof[i] = acc;
      end
      det = fx_mul(mat_copy[0], cof[0]);
      det = fx_addsub(det, fx_mul(mat_copy[4], cof[1]), 1'b0);
      det = fx_addsub(det, fx_mul(mat_copy[8], cof[2]), 1'b0);
      det = fx_addsub(det, fx_mul(mat_copy[12], cof[3]), 1'b0);
      mag = det[63] ? (64'd0 - 64'(det)) : 64'(det);
      sing = !(mag > 64'(thresh_copy));
      if (sing) begin
         fac = det;
      end else begin
         q = (64'd1 << (2 * FB)) / mag;
         fac = det[63] ? -$signed(q) : $signed(q);
      end
      for (int i = 0; i < 16; i++) begin
         t = fx_mul(cof[i], fac);
         if (t > 64'sh7FFFFFFF) t = 64'sh7FFFFFFF;
         if (t < -64'sh80000000) t = -64'sh80000000;
         e.value = t[31:0];
         e.index = 4'(i);
         e.singular = sing;
         e.last = (i == 15);
         inverse_q.push_back(e);
      end
      matrices++;
   endtask

   // Result side: random backpressure (none once stall_off is set), checked against the oldest expectation.
   initial begin
      int hold;
      inv_elem_type x;
      rsp_tready = 1'b0;
      hold = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (inverse_q.size() == 0) begin
               $error("unexpected result transfer: value %h", rsp_tdata);
               errors++;
            end else begin
               x = inverse_q.pop_front();
               if (rsp_tdata !== x.value) begin
                  $error("result_value: expected %h, actual %h", x.value, rsp_tdata);
                  errors++;
               end
               if (rsp_tuser[3:0] !== x.index) begin
                  $error("result_index: expected %0d, actual %0d", x.index, rsp_tuser[3:0]);
                  errors++;
               end
               if (rsp_tuser[4] !== x.singular) begin
                  $error("singular: expected %b, actual %b", x.singular, rsp_tuser[4]);
                  errors++;
               end
               if (rsp_tlast !== x.last) begin
                  $error("result_last: expected %b, actual %b", x.last, rsp_tlast);
                  errors++;
               end
            end
         end
         if (stall_off) begin
            rsp_tready <= 1'b1;
         end else if (hold > 0) begin
            hold--;
            rsp_tready <= 1'b0;
         end else if ($urandom_range(0, 7) == 0) begin
            hold = $urandom_range(1, 9);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // One element transfer, with an optional random idle burst before it.
   // The valid flag stays up after a transfer; an idle burst or the drain drops it.
   task automatic send_elem(logic signed [31:0] v, logic lst);
      if (!stall_off && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= v;
      req_tlast  <= lst;
      do @(posedge clock); while (!req_tready);
      predict_inverse(v, lst);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (inverse_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_threshold(logic [15:0] v);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we    <= 1'b0;
      thresh_copy = v;
   endtask

   function automatic logic signed [31:0] rand_elem(int mode);
      case (mode)
         0: return $urandom();
         1: return $signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000;
         default: return $signed($urandom_range(0, 32'h1FFF)) - 32'sh1000;
      endcase
   endfunction

   elem_row_type rows [$];
   initial begin
      elem_row_type r;
      logic signed [31:0] v;
      int mode, n;
      bit lst;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = '0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      errors = 0;
      matrices = 0;
      results_seen = 0;
      stall_off = 1'b0;
      fill_ptr = '0;
      thresh_copy = THR_RESET;
      for (int i = 0; i < 16; i++) mat_copy[i] = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table: the identity, whose inverse is itself; then one
      // matrix of field extremes, where saturation dominates.
      for (int i = 0; i < 16; i++) begin
         r.value = (i % 5 == 0) ? 32'sh10000 : 32'sh0;
         r.last = (i == 15);
         r.has_exp = 1'b1;
         r.exp_value = (i % 5 == 0) ? 32'sh10000 : 32'sh0;
         r.exp_singular = 1'b0;
         rows.push_back(r);
      end
      for (int i = 0; i < 16; i++) begin
         r.value = (i % 3 == 0) ? 32'sh7FFFFFFF : ((i % 3 == 1) ? -32'sh80000000 : 32'sh1);
         r.last = (i == 15);
         r.has_exp = 1'b0;
         rows.push_back(r);
      end
      foreach (rows[j]) begin
         send_elem(rows[j].value, rows[j].last);
         if (rows[j].last && rows[j].has_exp) begin
            if (inverse_q[inverse_q.size()-16].value !== rows[j].exp_value) begin
               $error("result_value: expected %h, actual %h", rows[j].exp_value,
                      inverse_q[inverse_q.size()-16].value);
               errors++;
            end
         end
      end
      wait_drained();
      // All-zero matrix is singular; a short early-last run reuses old entries.
      for (int i = 0; i < 16; i++) send_elem(32'sh0, i == 15);
      for (int i = 0; i < 3; i++) send_elem(rand_elem(2), i == 2);
      wait_drained();

      // Random phases over several thresholds, the extremes among them.
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: write_threshold(16'd0);
            1: write_threshold(16'hFFFF);
            2: write_threshold(16'($urandom_range(0, 16'hFFFF)));
            3: write_threshold(16'd1);
            default: write_threshold(16'($urandom_range(0, 255)));
         endcase
         if (ph == 4) stall_off = 1'b1;
         for (int m = 0; m < 6; m++) begin
            mode = $urandom_range(0, 2);
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 24) : 16;
            for (int i = 0; i < n; i++) begin
               v = rand_elem(mode);
               lst = (i == n - 1);
               // Near-identity matrices exercise well-conditioned inverses.
               if (mode == 2 && i % 5 == 0 && $urandom_range(0, 1)) v = v + 32'sh10000;
               send_elem(v, lst);
            end
         end
         wait_drained();
      end

      $display("Covered %0d matrices and %0d result transfers over five thresholds.",
               matrices, results_seen);
      if (errors == 0) begin
         $display("** matrix_inverse_4x4: PASSED **");
      end else begin
         $display("** matrix_inverse_4x4: FAILED **");
      end
      $finish;
   end

endmodule
